// ===== rtl/mapped_region_table_macros.svh =====
// Assertion macros shared by the checker of the mapped region table.
`ifndef MAPPED_REGION_TABLE_MACROS_SVH
`define MAPPED_REGION_TABLE_MACROS_SVH
// Asserts that an antecedent implies a consequent in the same cycle.
`define MRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Asserts that an antecedent implies a consequent in the next cycle.
`define MRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/mrt_pkg.sv =====
// Package with the types, codes and helpers of the mapped region table.
package mrt_pkg;
    localparam int ADDR_W = 38;
    localparam int LEN_W = 39;
    localparam int OFF_W = 32;
    localparam int FILE_W = 8;
    localparam int IDX_W = 4;
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_PAGE_BYTES = 4096;

    localparam logic [1:0] MODE_MAP = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_UNMAP = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_HOLE = 3'd4;

    // Byte address of the ceiling register on the configuration port.
    localparam logic [2:0] REG_MAP_CEILING = 3'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_READ,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  size;
        logic [2:0]        prot;
        logic [1:0]        flags;
        logic [FILE_W-1:0] file;
        logic [OFF_W-1:0]  offset;
    } entry_t;
endpackage

// ===== rtl/mrt_store.sv =====
// Region store: one synchronous memory with registered read and valid flops.
module mrt_store #(
    parameter int TABLE_ENTRIES = mrt_pkg::DEF_TABLE_ENTRIES,
    parameter int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IW-1:0]       raddr,
    output mrt_pkg::entry_t     rdata,
    output logic                rvalid,
    input  logic                we,
    input  logic [IW-1:0]       waddr,
    input  mrt_pkg::entry_t     wdata,
    input  logic                wvalid
);
    import mrt_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    entry_t rdata_reg;
    logic rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= wvalid;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign rvalid = rvalid_reg;
endmodule

// ===== rtl/mapped_region_table.sv =====
// Top level of the mapped region table: command port, scan sequencer and config register.
// An operation is taken when start is high and busy is low; its one result appears on the
// result ports for exactly one cycle with done high, and the receiver cannot stall it.
// Every operation scans the whole table through the single read port of the region
// memory, one entry per cycle. Maps, misses and refused commands are decided after
// the scan; a lookup or unmap hit is first reread from the memory, and an unmap
// that is not a hole writes the entry back. busy is already low in the done cycle,
// so the next command may be accepted at the edge that ends it.
module mapped_region_table #(
    parameter int TABLE_ENTRIES = mrt_pkg::DEF_TABLE_ENTRIES,
    parameter int PAGE_BYTES = mrt_pkg::DEF_PAGE_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  mode,
    input  logic [mrt_pkg::ADDR_W-1:0]  address,
    input  logic [mrt_pkg::LEN_W-1:0]   length,
    input  logic [2:0]                  prot,
    input  logic [1:0]                  map_flags,
    input  logic [mrt_pkg::FILE_W-1:0]  file_id,
    input  logic                        file_readable,
    input  logic                        file_writable,
    input  logic [mrt_pkg::OFF_W-1:0]   file_offset,
    output logic                        done,
    output logic [2:0]                  status,
    output logic [mrt_pkg::ADDR_W-1:0]  result_address,
    output logic [mrt_pkg::LEN_W-1:0]   span_bytes,
    output logic [mrt_pkg::IDX_W-1:0]   entry_index,
    output logic [mrt_pkg::FILE_W-1:0]  region_file,
    output logic [mrt_pkg::OFF_W-1:0]   page_file_offset,
    output logic [3:0]                  page_perm,
    output logic                        entry_freed,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import mrt_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PB = $clog2(PAGE_BYTES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [LEN_W-1:0] ADDR_TOP = LEN_W'(1) << ADDR_W;
    localparam logic [LEN_W-1:0] PMASK = ~((LEN_W'(1) << PB) - LEN_W'(1));
    localparam logic [LEN_W-1:0] PM1 = (LEN_W'(1) << PB) - LEN_W'(1);

    // The ceiling is 39 bits wide, so the data bus is 64 bits and the register sits
    // at byte address 0.
    logic [LEN_W-1:0] ceil_reg;
    logic pwr;
    assign pwr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg <= ADDR_TOP;
        end
        else if (pwr && paddr == REG_MAP_CEILING)
        begin
            ceil_reg <= pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = 64'd0;
        if (paddr == REG_MAP_CEILING)
        begin
            prdata = {25'd0, ceil_reg};
        end
    end

    // Operation registers.
    state_t state_reg, state_next;
    logic [1:0] mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0] len_reg;
    logic [2:0] prot_reg;
    logic [1:0] flags_reg;
    logic [FILE_W-1:0] fid_reg;
    logic rd_reg, wr_reg;
    logic [OFF_W-1:0] foff_reg;
    logic [IW-1:0] scan_reg;
    logic [LEN_W-1:0] top_reg;
    logic free_found_reg, hit_reg;
    logic [IW-1:0] free_reg, hit_idx_reg;

    logic [IW-1:0] raddr;
    entry_t rdata, wdata;
    logic rvalid, we, wvalid;

    mrt_store #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .IW(IW)
    ) u_store (
        .clk(clk),
        .rst_n(rst_n),
        .raddr(raddr),
        .rdata(rdata),
        .rvalid(rvalid),
        .we(we),
        .waddr(state_reg == S_APPLY ? hit_idx_reg : free_reg),
        .wdata(wdata),
        .wvalid(wvalid)
    );

    // Scan evaluation of the entry read in the previous cycle.
    logic [LEN_W-1:0] r_end;
    logic r_hit;
    assign r_end = {1'b0, rdata.start} + rdata.size;
    assign r_hit = rvalid && ({1'b0, addr_reg} >= {1'b0, rdata.start})
                   && ({1'b0, addr_reg} < r_end);

    // Decision values for map. The rounded size keeps its carry so that a length
    // near the top of the field cannot wrap into a small size.
    logic [LEN_W:0] sz_w;
    logic [LEN_W-1:0] sz;
    logic sz_fits;
    logic denied;
    assign sz_w = ({1'b0, len_reg} + {1'b0, PM1}) & {1'b1, PMASK};
    assign sz = sz_w[LEN_W-1:0];
    assign sz_fits = sz_w <= {1'b0, top_reg};
    assign denied = (!rd_reg && prot_reg[0]) || (!wr_reg && prot_reg[1] && !flags_reg[1]);

    // Unmap arithmetic on the reread entry.
    logic [LEN_W:0] stop;
    logic [LEN_W-1:0] al, skip, new_size;
    logic [LEN_W:0] al_w;
    logic after_s, front;
    assign stop = {2'b0, addr_reg} + {1'b0, len_reg};
    assign after_s = addr_reg > rdata.start;
    assign al_w = ({2'b0, addr_reg} + {1'b0, PM1}) & {1'b1, PMASK};
    assign al = after_s ? al_w[LEN_W-1:0] : {1'b0, addr_reg};
    assign skip = al - {1'b0, addr_reg};
    assign front = !after_s && (stop > {2'b0, rdata.start});
    assign new_size = (rdata.size > len_reg) ? rdata.size - len_reg : '0;

    logic [ADDR_W-1:0] poff_delta;
    assign poff_delta = (addr_reg - rdata.start) & PMASK[ADDR_W-1:0];

    // Result registers.
    logic done_reg;
    logic [2:0] status_reg;
    logic [ADDR_W-1:0] raddr_out_reg;
    logic [LEN_W-1:0] span_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [FILE_W-1:0] rfile_reg;
    logic [OFF_W-1:0] poff_reg;
    logic [3:0] perm_reg;
    logic freed_reg;

    logic accept;
    assign accept = start && state_reg == S_IDLE;
    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        raddr = scan_reg;
        we = 1'b0;
        wvalid = 1'b1;
        wdata = rdata;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                raddr = hit_idx_reg;
                if (mode_reg == MODE_MAP)
                begin
                    state_next = S_IDLE;
                    wdata.start = ADDR_W'(top_reg - sz);
                    wdata.size = sz;
                    wdata.prot = prot_reg;
                    wdata.flags = flags_reg;
                    wdata.file = fid_reg;
                    wdata.offset = foff_reg;
                    we = len_reg != '0 && !denied && free_found_reg && sz_fits;
                end
                else if (hit_reg && (mode_reg == MODE_LOOKUP ||
                         (mode_reg == MODE_UNMAP && len_reg != '0)))
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                raddr = hit_idx_reg;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
                if (mode_reg == MODE_UNMAP && !(after_s && stop < {1'b0, r_end}))
                begin
                    we = 1'b1;
                    wdata.size = new_size;
                    wvalid = new_size != '0;
                    if (front)
                    begin
                        wdata.start = stop[ADDR_W-1:0];
                        wdata.offset = rdata.offset + OFF_W'(stop - {2'b0, rdata.start});
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            scan_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= 1'b0;
            if (accept)
            begin
                scan_reg <= '0;
            end
            else if (state_reg == S_SCAN && scan_reg != LAST_IDX)
            begin
                scan_reg <= scan_reg + IW'(1);
            end
            if ((state_reg == S_DECIDE && state_next == S_IDLE) || state_reg == S_APPLY)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            addr_reg <= address;
            len_reg <= length;
            prot_reg <= prot;
            flags_reg <= map_flags;
            fid_reg <= file_id;
            rd_reg <= file_readable;
            wr_reg <= file_writable;
            foff_reg <= file_offset;
            top_reg <= ((ceil_reg > ADDR_TOP) ? ADDR_TOP : ceil_reg) & PMASK;
            free_found_reg <= 1'b0;
            hit_reg <= 1'b0;
            free_reg <= '0;
            hit_idx_reg <= '0;
        end
        if ((state_reg == S_SCAN && scan_reg != '0) || state_reg == S_LAST)
        begin
            if (!rvalid)
            begin
                if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_reg <= state_reg == S_LAST ? LAST_IDX : scan_reg - IW'(1);
                end
            end
            else if ({1'b0, rdata.start} < top_reg)
            begin
                top_reg <= {1'b0, rdata.start} & PMASK;
            end
            if (r_hit && !hit_reg)
            begin
                hit_reg <= 1'b1;
                hit_idx_reg <= state_reg == S_LAST ? LAST_IDX : scan_reg - IW'(1);
            end
        end
        if ((state_reg == S_DECIDE && state_next == S_IDLE) || state_reg == S_APPLY)
        begin
            status_reg <= ST_INVALID;
            raddr_out_reg <= '0;
            span_reg <= '0;
            idx_reg <= '0;
            rfile_reg <= '0;
            poff_reg <= '0;
            perm_reg <= '0;
            freed_reg <= 1'b0;
            if (state_reg == S_DECIDE)
            begin
                if (mode_reg == MODE_MAP && len_reg != '0 && !denied)
                begin
                    if (!free_found_reg)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else if (sz_fits)
                    begin
                        status_reg <= ST_OK;
                        raddr_out_reg <= ADDR_W'(top_reg - sz);
                        idx_reg <= IDX_W'(free_reg);
                    end
                end
                else if (mode_reg == MODE_LOOKUP ||
                         (mode_reg == MODE_UNMAP && len_reg != '0))
                begin
                    status_reg <= ST_NOT_FOUND;
                end
            end
            else
            begin
                idx_reg <= IDX_W'(hit_idx_reg);
                rfile_reg <= rdata.file;
                if (mode_reg == MODE_LOOKUP)
                begin
                    status_reg <= ST_OK;
                    poff_reg <= rdata.offset + OFF_W'(poff_delta);
                    perm_reg <= {rdata.prot, 1'b1};
                end
                else if (after_s && stop < {1'b0, r_end})
                begin
                    status_reg <= ST_HOLE;
                end
                else
                begin
                    status_reg <= ST_OK;
                    raddr_out_reg <= al[ADDR_W-1:0];
                    span_reg <= (len_reg > skip) ? len_reg - skip : '0;
                    freed_reg <= new_size == '0;
                end
            end
        end
    end

    assign done = done_reg;
    assign status = status_reg;
    assign result_address = raddr_out_reg;
    assign span_bytes = span_reg;
    assign entry_index = idx_reg;
    assign region_file = rfile_reg;
    assign page_file_offset = poff_reg;
    assign page_perm = perm_reg;
    assign entry_freed = freed_reg;
endmodule

// ===== rtl/mrt_checker.sv =====
// Port-level checker of the mapped region table and its bind.
`include "mapped_region_table_macros.svh"
module mrt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic       entry_freed,
    input logic       pready
);
    import mrt_pkg::*;

    `MRT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy,
        "accepted transfer did not raise busy")
    `MRT_ASSERT_IMP(a_done_pulse, clk, rst_n, done, !$past(done),
        "result shown for more than one cycle")
    `MRT_ASSERT_IMP(a_status_range, clk, rst_n, done, status <= ST_HOLE,
        "status code out of range")
    `MRT_ASSERT_IMP(a_freed_ok, clk, rst_n, done && entry_freed, status == ST_OK,
        "entry freed without ok status")
    `MRT_ASSERT_IMP(a_ready, clk, rst_n, 1'b1, pready,
        "config port not ready")
endmodule

bind mapped_region_table mrt_checker u_mrt_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .status(status),
    .entry_freed(entry_freed),
    .pready(pready)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the mapped region table: map, lookup and unmap traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrt_pkg::*;

    // The block decodes only three of the four mode values; the fourth must be refused.
    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int ENTRIES = 16;
    localparam logic [63:0] PAGE = 64'd4096;
    localparam logic [63:0] SPACE_TOP = 64'h40_0000_0000;
    localparam logic [63:0] MASK38 = SPACE_TOP - 64'd1;
    localparam logic [63:0] MASK39 = 64'h7F_FFFF_FFFF;
    localparam int DRAIN_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int RANDOM_PER_PHASE = 305;
    localparam int PHASES = 6;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [2:0]        prot;
        logic [1:0]        map_flags;
        logic [FILE_W-1:0] file_id;
        logic              file_readable;
        logic              file_writable;
        logic [OFF_W-1:0]  file_offset;
    } region_cmd_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic [LEN_W-1:0]  span_bytes;
        logic [IDX_W-1:0]  entry_index;
        logic [FILE_W-1:0] region_file;
        logic [OFF_W-1:0]  page_file_offset;
        logic [3:0]        page_perm;
        logic              entry_freed;
    } region_reply_t;

    typedef struct {
        region_cmd_t   cmd;
        bit            typed;
        region_reply_t want;
    } directed_row_t;

    // Clock, reset and the ports of the block. Every input starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] mode = MODE_MAP;
    logic [ADDR_W-1:0] address = '0;
    logic [LEN_W-1:0] length = '0;
    logic [2:0] prot = '0;
    logic [1:0] map_flags = '0;
    logic [FILE_W-1:0] file_id = '0;
    logic file_readable = 1'b0;
    logic file_writable = 1'b0;
    logic [OFF_W-1:0] file_offset = '0;
    logic done;
    logic [2:0] status;
    logic [ADDR_W-1:0] result_address;
    logic [LEN_W-1:0] span_bytes;
    logic [IDX_W-1:0] entry_index;
    logic [FILE_W-1:0] region_file;
    logic [OFF_W-1:0] page_file_offset;
    logic [3:0] page_perm;
    logic entry_freed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    mapped_region_table uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .address(address), .length(length), .prot(prot), .map_flags(map_flags),
        .file_id(file_id), .file_readable(file_readable), .file_writable(file_writable),
        .file_offset(file_offset), .done(done), .status(status),
        .result_address(result_address), .span_bytes(span_bytes),
        .entry_index(entry_index), .region_file(region_file),
        .page_file_offset(page_file_offset), .page_perm(page_perm),
        .entry_freed(entry_freed), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Shadow copy of the region table and the ceiling register. Starts, sizes and the
    // ceiling are held in 64-bit vectors so that sums such as start plus size never wrap.
    bit          shadow_valid [ENTRIES];
    logic [63:0] shadow_start [ENTRIES];
    logic [63:0] shadow_size [ENTRIES];
    logic [2:0]  shadow_prot [ENTRIES];
    logic [1:0]  shadow_flags [ENTRIES];
    logic [7:0]  shadow_file [ENTRIES];
    logic [31:0] shadow_offset [ENTRIES];
    logic [63:0] shadow_ceiling = SPACE_TOP;

    region_reply_t pending_replies [$];
    int mismatches = 0;
    longint cycles = 0;
    int idle_percent = 0;

    function automatic logic [63:0] page_floor(input logic [63:0] v);
        return (v / PAGE) * PAGE;
    endfunction

    function automatic logic [63:0] page_ceil(input logic [63:0] v);
        return page_floor(v + PAGE - 64'd1);
    endfunction

    function automatic int region_holding(input logic [63:0] va);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && va >= shadow_start[i] &&
                va < shadow_start[i] + shadow_size[i])
                return i;
        return -1;
    endfunction

    // Applies one command to the shadow table and returns the reply it must produce.
    // Fields that a mode or status leaves undefined stay zero.
    function automatic region_reply_t apply_region_cmd(input region_cmd_t c);
        region_reply_t r;
        logic [63:0] a, len, sz, top, s, stop, aligned, skip;
        int hit, slot;
        bit denied;
        r = '0;
        r.status = ST_INVALID;
        a = 64'(c.address);
        len = 64'(c.length);
        if (c.mode == MODE_MAP) begin
            // A read needs a readable file; a write needs a writable one unless private.
            denied = (!c.file_readable && c.prot[0]) ||
                     (!c.file_writable && c.prot[1] && !c.map_flags[1]);
            if (len != 0 && !denied) begin
                sz = page_ceil(len);
                top = page_floor(shadow_ceiling > SPACE_TOP ? SPACE_TOP : shadow_ceiling);
                slot = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!shadow_valid[i]) begin
                        if (slot < 0)
                            slot = i;
                    end else if (shadow_start[i] < top) begin
                        top = page_floor(shadow_start[i]);
                    end
                end
                if (slot < 0) begin
                    r.status = ST_FULL;
                end else if (sz <= top) begin
                    shadow_valid[slot] = 1'b1;
                    shadow_start[slot] = (top - sz) & MASK38;
                    shadow_size[slot] = sz & MASK39;
                    shadow_prot[slot] = c.prot;
                    shadow_flags[slot] = c.map_flags;
                    shadow_file[slot] = c.file_id;
                    shadow_offset[slot] = c.file_offset;
                    r.status = ST_OK;
                    r.result_address = shadow_start[slot][ADDR_W-1:0];
                    r.entry_index = slot[IDX_W-1:0];
                end
            end
        end else if (c.mode == MODE_LOOKUP) begin
            hit = region_holding(a);
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.status = ST_OK;
                r.entry_index = hit[IDX_W-1:0];
                r.region_file = shadow_file[hit];
                r.page_file_offset = 32'(64'(shadow_offset[hit]) +
                                         page_floor(a - shadow_start[hit]));
                r.page_perm = {shadow_prot[hit], 1'b1};
            end
        end else if (c.mode == MODE_UNMAP && len != 0) begin
            hit = region_holding(a);
            if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                s = shadow_start[hit];
                stop = a + len;
                r.entry_index = hit[IDX_W-1:0];
                if (a > s && stop < s + shadow_size[hit]) begin
                    // Punching a hole in the middle is refused and changes nothing.
                    r.status = ST_HOLE;
                    r.region_file = shadow_file[hit];
                end else begin
                    aligned = a > s ? page_ceil(a) : a;
                    skip = aligned - a;
                    r.span_bytes = 39'(len > skip ? len - skip : 64'd0);
                    r.result_address = aligned[ADDR_W-1:0];
                    if (a <= s && stop > s) begin
                        shadow_offset[hit] = 32'(64'(shadow_offset[hit]) + (stop - s));
                        shadow_start[hit] = stop & MASK38;
                    end
                    shadow_size[hit] = shadow_size[hit] > len ? shadow_size[hit] - len : 64'd0;
                    if (shadow_size[hit] == 0) begin
                        shadow_valid[hit] = 1'b0;
                        r.entry_freed = 1'b1;
                    end
                    r.status = ST_OK;
                    r.region_file = shadow_file[hit];
                end
            end
        end
        return r;
    endfunction

    function automatic region_cmd_t make_cmd(input logic [1:0] m, input logic [63:0] a,
                                             input logic [63:0] len, input logic [2:0] p,
                                             input logic [1:0] f, input logic [7:0] fid,
                                             input bit rd, input bit wr,
                                             input logic [31:0] foff);
        region_cmd_t c;
        c.mode = m;
        c.address = a[ADDR_W-1:0];
        c.length = len[LEN_W-1:0];
        c.prot = p;
        c.map_flags = f;
        c.file_id = fid;
        c.file_readable = rd;
        c.file_writable = wr;
        c.file_offset = foff;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random command. Most unmaps and lookups aim at regions that exist, so that
    // trims, holes, frees and page offsets are reached often; the rest is noise.
    function automatic region_cmd_t random_region_cmd();
        region_cmd_t c;
        logic [63:0] a, len, s, z, k;
        int live [$];
        int pick, e;
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i])
                live.push_back(i);
        c = make_cmd(MODE_MAP, rand64() & MASK38, 64'd0, 3'($urandom), 2'($urandom),
                     8'($urandom), $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                     $urandom);
        pick = $urandom_range(0, 99);
        e = live.size() > 0 ? live[$urandom_range(0, live.size() - 1)] : -1;
        if (e >= 0) begin
            s = shadow_start[e];
            z = shadow_size[e];
        end
        if (pick < 40) begin
            case ($urandom_range(0, 19))
                0:       len = SPACE_TOP;
                1:       len = rand64() & MASK38;
                2, 3, 4: len = PAGE * $urandom_range(1, 8);
                5:       len = 64'd0;
                default: len = $urandom_range(1, 20000);
            endcase
            c.length = len[LEN_W-1:0];
        end else if (pick < 70) begin
            c.mode = MODE_LOOKUP;
            if (e >= 0 && $urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 5))
                    0:       a = s;
                    1:       a = s + z - 1;
                    2:       a = s - 1;
                    3:       a = s + z;
                    default: a = s + rand64() % z;
                endcase
                c.address = a[ADDR_W-1:0];
            end
        end else if (pick < 96) begin
            c.mode = MODE_UNMAP;
            len = $urandom_range(1, 20000);
            if (e >= 0 && $urandom_range(0, 99) < 85) begin
                k = 64'd1 + rand64() % z;
                case ($urandom_range(0, 5))
                    0: begin a = s; len = 1 + rand64() % (z + PAGE); end
                    1: begin a = s + z - k; len = k + $urandom_range(0, 8192); end
                    2: begin a = s + rand64() % z; end
                    3: begin a = s; len = z; end
                    4: begin a = s; len = z + $urandom_range(1, 1 << 20); end
                    default: begin a = s + z - k; len = k; end
                endcase
                c.address = a[ADDR_W-1:0];
            end
            if ($urandom_range(0, 29) == 0)
                len = 64'd0;
            if (len > SPACE_TOP)
                len = SPACE_TOP;
            c.length = len[LEN_W-1:0];
        end else begin
            c.mode = $urandom_range(0, 9) < 5 ? MODE_RESERVED : 2'($urandom);
            len = rand64() & MASK38;
            c.length = len[LEN_W-1:0];
        end
        return c;
    endfunction

    function automatic int idle_gap();
        int g = 0;
        while (g < 60 && $urandom_range(0, 99) < idle_percent)
            g++;
        return g;
    endfunction

    // Drives one command and holds it until the block takes it. The expectation is
    // queued at the transfer edge. With gap zero start stays high for the next one.
    task automatic issue_cmd(input region_cmd_t c, input bit typed,
                             input region_reply_t want, input int gap);
        region_reply_t predicted;
        mode <= c.mode;
        address <= c.address;
        length <= c.length;
        prot <= c.prot;
        map_flags <= c.map_flags;
        file_id <= c.file_id;
        file_readable <= c.file_readable;
        file_writable <= c.file_writable;
        file_offset <= c.file_offset;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        predicted = apply_region_cmd(c);
        pending_replies.push_back(typed ? want : predicted);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // The ceiling fits the 64-bit data bus in one write at its own address.
    task automatic write_ceiling(input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_MAP_CEILING;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        shadow_ceiling = value & MASK39;
    endtask

    task automatic drain_replies();
        while (pending_replies.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Every done cycle carries one result; it is matched against the oldest expectation.
    always @(posedge clk) begin
        region_reply_t want, got;
        if (rst_n && done) begin
            got = '{status, result_address, span_bytes, entry_index, region_file,
                    page_file_offset, page_perm, entry_freed};
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("mapped_region_table regression: fail");
            $finish;
        end
    end

    directed_row_t rows [$];
    logic [63:0] ceiling_plan [PHASES] = '{SPACE_TOP, 64'd0, MASK39, 64'h1_0000_0800,
                                           64'h10_5000, SPACE_TOP};
    int idle_plan [PHASES] = '{0, 87, 0, 28, 87, 0};

    initial begin
        region_reply_t refused, missing, whole;
        logic [63:0] base;
        refused = '0;
        refused.status = ST_INVALID;
        missing = '0;
        missing.status = ST_NOT_FOUND;
        // A map reports only its start and its entry; the file is not echoed.
        whole = '0;
        whole.status = ST_OK;
        // Regions are placed downward from the top of the address space.
        base = SPACE_TOP - 64'd24576;
        rows = '{
            '{make_cmd(MODE_LOOKUP, 0, 0, 0, 0, 0, 1, 1, 0), 1, missing},
            '{make_cmd(MODE_UNMAP, 0, 0, 0, 0, 0, 1, 1, 0), 1, refused},
            '{make_cmd(MODE_MAP, 0, 0, 3'b001, 2'b01, 1, 1, 1, 0), 1, refused},
            '{make_cmd(MODE_MAP, 0, 4096, 3'b001, 2'b01, 1, 0, 1, 0), 1, refused},
            '{make_cmd(MODE_MAP, 0, 4096, 3'b010, 2'b01, 1, 1, 0, 0), 1, refused},
            '{make_cmd(MODE_RESERVED, MASK38, MASK39, 7, 3, 255, 1, 1, 32'hFFFF_FFFF),
              1, refused},
            // A single region that covers the whole address space.
            '{make_cmd(MODE_MAP, 0, SPACE_TOP, 3'b111, 2'b10, 8'hA5, 1, 1, 0), 1, whole},
            '{make_cmd(MODE_LOOKUP, MASK38, 0, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_UNMAP, 0, SPACE_TOP, 0, 0, 0, 0, 0, 0), 0, refused},
            // Private writable mapping of an unwritable file, offset at its maximum.
            '{make_cmd(MODE_MAP, 0, 4096, 3'b010, 2'b10, 8'hFF, 0, 0, 32'hFFFF_FFFF),
              0, refused},
            '{make_cmd(MODE_MAP, 0, 1, 3'b101, 2'b01, 8'h3C, 1, 0, 32'h1234_5000), 0, refused},
            '{make_cmd(MODE_MAP, 0, 12289, 3'b011, 2'b11, 8'h5A, 1, 1, 32'h8000), 0, refused},
            '{make_cmd(MODE_LOOKUP, base + 8199, 0, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_UNMAP, base + 4096, 4096, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_UNMAP, base, 4096, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_UNMAP, SPACE_TOP - 8292, 200, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_UNMAP, SPACE_TOP - 4096, 10, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_UNMAP, SPACE_TOP - 8192, SPACE_TOP, 0, 0, 0, 0, 0, 0),
              0, refused},
            '{make_cmd(MODE_LOOKUP, MASK38, 0, 0, 0, 0, 0, 0, 0), 0, refused},
            '{make_cmd(MODE_LOOKUP, SPACE_TOP - 8192, 0, 0, 0, 0, 0, 0, 0), 0, refused}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            issue_cmd(rows[i].cmd, rows[i].typed, rows[i].want,
                      i == rows.size() - 1 ? 1 : $urandom_range(0, 2));

        // Each phase runs with its own ceiling and its own idling pattern. The
        // register is only touched once the block has gone quiet.
        for (int p = 0; p < PHASES; p++) begin
            drain_replies();
            write_ceiling(ceiling_plan[p]);
            idle_percent = idle_plan[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                issue_cmd(random_region_cmd(), 0, refused,
                          n == RANDOM_PER_PHASE - 1 ? 1 : idle_gap());
        end
        drain_replies();

        if (mismatches == 0)
            $display("mapped_region_table regression: pass");
        else
            $display("mapped_region_table regression: fail");
        $finish;
    end
endmodule

// ===== mapped_region_table.f =====
+incdir+rtl
rtl/mrt_pkg.sv
rtl/mrt_store.sv
rtl/mapped_region_table.sv
rtl/mrt_checker.sv
bench/tb.sv
